// ===== rtl/sahc_pkg.sv =====
// Shared types and constants for the sorted address hit counter.
// No dependencies; imported by the datapath, controller, top module and testbench.
package sahc_pkg;

    localparam int CAPACITY    = 1024;
    localparam int IDX_W       = $clog2(CAPACITY);
    localparam int CNT_W       = $clog2(CAPACITY + 1);
    localparam int ADDR_W      = 32;
    localparam int HITS_W      = 32;
    localparam int ENTRIES_W   = 11;
    localparam int IN_TDATA_W  = 32;
    localparam int OUT_FIELD_W = 1 + HITS_W + ENTRIES_W + 1;
    localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;
    localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_FIELD_W;

    localparam logic [HITS_W-1:0] HITS_MAX = '1;

    // op codes carried on s_axis_tuser
    localparam logic OP_COUNT  = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    typedef struct packed {
        logic [HITS_W-1:0] hits;
        logic [ADDR_W-1:0] addr;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    // controller -> datapath
    typedef struct packed {
        logic load;       // latch accepted item, open search window
        logic rd_mid;     // probe read at window midpoint
        logic narrow;     // compare probe, shrink window
        logic rd_lo;      // read final slot
        logic eval;       // decide result, write bumped count on a counting hit
        logic shift_top;  // read last valid entry, start move
        logic shift_mv;   // move one entry up, read next one down
        logic ins;        // write new entry, grow table
        logic res_load;   // load output register
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic lo_lt_hi;
        logic hit;
        logic lookup;
        logic full;
        logic lo_eq_cnt;
        logic ptr_eq_lo;
        logic out_free;
    } t_stat;

endpackage

// ===== rtl/sahc_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Standalone; used for the entry table.
module sahc_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/sahc_dp.sv =====
// Datapath: search window, entry table RAM, shift pointer, result and output registers.
// Depends on sahc_pkg and sahc_ram.
module sahc_dp
    import sahc_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_cmd                   i_cmd,
    output t_stat                  o_stat,
    input  logic                   i_in_op,
    input  logic [ADDR_W-1:0]      i_in_addr,
    input  logic                   i_out_ready,
    output logic                   o_out_valid,
    output logic [OUT_TDATA_W-1:0] o_out_data
);

    logic                   r_op;
    logic [ADDR_W-1:0]      r_key;
    logic [CNT_W-1:0]       r_lo;
    logic [CNT_W-1:0]       r_hi;
    logic [CNT_W-1:0]       r_count;
    logic [IDX_W-1:0]       r_ptr;
    logic                   r_found;
    logic [HITS_W-1:0]      r_hits;
    logic                   r_drop;
    logic                   r_out_valid;
    logic [OUT_TDATA_W-1:0] r_out_data;

    logic [CNT_W-1:0]  mid;
    logic [IDX_W-1:0]  lo_idx;
    logic              full;
    logic              hit_now;
    logic [HITS_W-1:0] cnt_inc;
    logic              we;
    logic [IDX_W-1:0]  wr_addr;
    t_entry            wr_entry;
    logic [IDX_W-1:0]  rd_addr;
    logic [ENTRY_W-1:0] rd_data;
    t_entry            rd_entry;

    assign mid      = r_lo + ((r_hi - r_lo) >> 1);
    assign lo_idx   = r_lo[IDX_W-1:0];
    assign full     = (r_count == CNT_W'(CAPACITY));
    assign rd_entry = t_entry'(rd_data);
    assign hit_now  = (r_lo < r_count) && (rd_entry.addr == r_key);
    assign cnt_inc  = (rd_entry.hits == HITS_MAX) ? rd_entry.hits
                                                  : rd_entry.hits + HITS_W'(1);

    always_comb begin
        rd_addr = '0;
        if (i_cmd.rd_mid) begin
            rd_addr = mid[IDX_W-1:0];
        end else if (i_cmd.rd_lo) begin
            rd_addr = lo_idx;
        end else if (i_cmd.shift_top) begin
            rd_addr = IDX_W'(r_count - CNT_W'(1));
        end else if (i_cmd.shift_mv) begin
            rd_addr = r_ptr - IDX_W'(1);
        end
    end

    always_comb begin
        we       = 1'b0;
        wr_addr  = lo_idx;
        wr_entry = rd_entry;
        if (i_cmd.eval) begin
            we            = hit_now && (r_op == OP_COUNT);
            wr_entry.addr = r_key;
            wr_entry.hits = cnt_inc;
        end else if (i_cmd.shift_mv) begin
            we      = 1'b1;
            wr_addr = r_ptr + IDX_W'(1);
        end else if (i_cmd.ins) begin
            we            = 1'b1;
            wr_entry.addr = r_key;
            wr_entry.hits = HITS_W'(1);
        end
    end

    sahc_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (CAPACITY)
    ) u_table (
        .i_clk     (i_clk),
        .i_we      (we),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_entry),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op  <= i_in_op;
            r_key <= i_in_addr;
            r_lo  <= '0;
            r_hi  <= r_count;
        end
        if (i_cmd.narrow) begin
            if (rd_entry.addr < r_key) begin
                r_lo <= mid + CNT_W'(1);
            end else begin
                r_hi <= mid;
            end
        end
        if (i_cmd.eval) begin
            r_found <= hit_now;
            r_drop  <= !hit_now && (r_op == OP_COUNT) && full;
            if (hit_now) begin
                r_hits <= (r_op == OP_COUNT) ? cnt_inc : rd_entry.hits;
            end else if ((r_op == OP_COUNT) && !full) begin
                r_hits <= HITS_W'(1);
            end else begin
                r_hits <= '0;
            end
        end
        if (i_cmd.shift_top) begin
            r_ptr <= IDX_W'(r_count - CNT_W'(1));
        end else if (i_cmd.shift_mv && (r_ptr != lo_idx)) begin
            r_ptr <= r_ptr - IDX_W'(1);
        end
        if (i_cmd.res_load) begin
            r_out_data <= {{OUT_PAD_W{1'b0}}, r_drop, ENTRIES_W'(r_count), r_hits, r_found};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.ins) begin
                r_count <= r_count + CNT_W'(1);
            end
            if (i_cmd.res_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_stat.lo_lt_hi  = (r_lo < r_hi);
    assign o_stat.hit       = hit_now;
    assign o_stat.lookup    = (r_op == OP_LOOKUP);
    assign o_stat.full      = full;
    assign o_stat.lo_eq_cnt = (r_lo == r_count);
    assign o_stat.ptr_eq_lo = (r_ptr == lo_idx);
    assign o_stat.out_free  = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

// ===== rtl/sahc_ctrl.sv =====
// Controller state machine: sequences search, update, shift and insert steps.
// Depends on sahc_pkg.
module sahc_ctrl
    import sahc_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_SRCH  = 7'b0000010,
        S_CMP   = 7'b0000100,
        S_HIT   = 7'b0001000,
        S_SHIFT = 7'b0010000,
        S_INS   = 7'b0100000,
        S_DONE  = 7'b1000000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_SRCH;
                end
            end
            S_SRCH: begin
                if (i_stat.lo_lt_hi) begin
                    o_cmd.rd_mid = 1'b1;
                    n_state      = S_CMP;
                end else begin
                    o_cmd.rd_lo = 1'b1;
                    n_state     = S_HIT;
                end
            end
            S_CMP: begin
                o_cmd.narrow = 1'b1;
                n_state      = S_SRCH;
            end
            S_HIT: begin
                o_cmd.eval = 1'b1;
                priority if (i_stat.hit || i_stat.lookup || i_stat.full) begin
                    n_state = S_DONE;
                end else if (i_stat.lo_eq_cnt) begin
                    n_state = S_INS;
                end else begin
                    o_cmd.shift_top = 1'b1;
                    n_state         = S_SHIFT;
                end
            end
            S_SHIFT: begin
                o_cmd.shift_mv = 1'b1;
                if (i_stat.ptr_eq_lo) begin
                    n_state = S_INS;
                end
            end
            S_INS: begin
                o_cmd.ins = 1'b1;
                n_state   = S_DONE;
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.res_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

endmodule

// ===== rtl/sorted_address_hit_counter_unit.sv =====
// Sorted address hit counter: binary search over a sorted address table with hit counts.
// Steps: accept, a midpoint read and a compare per probe (up to 11 at 1024 entries), a final
// read, evaluate, one move per entry at or above the insert point, insert, output load.
// One item in flight; the next transfer is taken once the result sits in the output register.
// The move loop (one RAM read and one write per cycle) sets the worst case.
// Synchronous active-low reset empties the table at once; no clearing pass is needed.
module sorted_address_hit_counter_unit
    import sahc_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // [31:0] addr
    input  logic                   s_axis_tuser,   // [0] op
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata    // [0] found, [32:1] hits,
                                                   // [43:33] entries, [44] dropped
);

    t_cmd  cmd;
    t_stat stat;

    sahc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    sahc_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_in_op     (s_axis_tuser),
        .i_in_addr   (s_axis_tdata[ADDR_W-1:0]),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out_data  (m_axis_tdata)
    );

endmodule

// ===== test/tb_sorted_address_hit_counter_unit.sv =====
// Testbench for sorted_address_hit_counter_unit: stream driver, stream monitor and a
// table predictor that mirrors the sorted address/count store. Depends on sahc_pkg.
// Self-checking; needs only the RTL.
`timescale 1ns / 1ps

module tb_sorted_address_hit_counter_unit;
    import sahc_pkg::*;

    // timeout that ends a hung run; the slowest correct run stays below it
    localparam int CYCLE_LIMIT = 10_000_000;
    localparam int DRAIN_WAIT  = 64;

    typedef struct packed {
        logic              op;
        logic [ADDR_W-1:0] addr;
        logic              drain;    // sender waits for every result before this one
    } t_probe;

    typedef struct packed {
        logic                 found;
        logic [HITS_W-1:0]    hits;
        logic [ENTRIES_W-1:0] entries;
        logic                 dropped;
    } t_tally;

    logic                   i_clk;
    logic                   i_rst_n       = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;   // [31:0] addr
    logic                   s_axis_tuser  = 1'b0; // [0] op
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;         // [0] found, [32:1] hits,
                                                  // [43:33] entries, [44] dropped

    // predictor state
    logic [ADDR_W-1:0] addr_tbl [CAPACITY];
    logic [HITS_W-1:0] hits_tbl [CAPACITY];
    int                stored;

    t_probe      pending [$];
    t_tally      tally_q [$];
    logic [31:0] known   [$];
    bit          issued  [logic [31:0]];

    int errors;
    int sent;
    int results;
    int n_found;
    int n_dropped;
    int peak_entries;
    int cycles;

    sorted_address_hit_counter_unit u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    // Binary search, then count, insert with shift-up, or drop when full; a lookup only reads.
    function automatic t_tally table_update(logic op, logic [ADDR_W-1:0] key);
        int     lo;
        int     hi;
        int     mid;
        int     k;
        t_tally r;
        lo = 0;
        hi = stored;
        while (lo < hi) begin
            mid = lo + (hi - lo) / 2;
            if (addr_tbl[mid] < key) lo = mid + 1;
            else hi = mid;
        end
        r = '0;
        r.found = (lo < stored) && (addr_tbl[lo] == key);
        if (r.found) begin
            if (op == OP_COUNT && hits_tbl[lo] != HITS_MAX) hits_tbl[lo] = hits_tbl[lo] + 1;
            r.hits = hits_tbl[lo];
        end else if (op == OP_COUNT) begin
            if (stored >= CAPACITY) begin
                r.dropped = 1'b1;
            end else begin
                for (k = stored; k > lo; k--) begin
                    addr_tbl[k] = addr_tbl[k-1];
                    hits_tbl[k] = hits_tbl[k-1];
                end
                addr_tbl[lo] = key;
                hits_tbl[lo] = 1;
                stored++;
                r.hits = 1;
            end
        end
        r.entries = ENTRIES_W'(stored);
        return r;
    endfunction

    // mostly short gaps, now and then a long one
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    function automatic void add_probe(logic op, logic [31:0] addr, logic drain);
        t_probe p;
        p.op    = op;
        p.addr  = addr;
        p.drain = drain;
        pending.push_back(p);
        if (op == OP_COUNT && !issued.exists(addr)) begin
            issued[addr] = 1'b1;
            known.push_back(addr);
        end
    endfunction

    function automatic logic [31:0] pick_known();
        // favor the oldest few so some counts climb high
        if ($urandom_range(0, 1) == 0)
            return known[$urandom_range(0, (known.size() > 8) ? 7 : known.size() - 1)];
        return known[$urandom_range(0, known.size() - 1)];
    endfunction

    function automatic logic [31:0] pick_absent();
        logic [31:0] a;
        a = $urandom();
        while (issued.exists(a)) a = $urandom();
        return a;
    endfunction

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
            errors++;
        end
    endtask

    // driver
    always @(posedge i_clk) begin
        logic   offer;
        int     gap_left;
        t_probe p;
        t_tally t;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            gap_left = 0;
        end else begin
            offer = s_axis_tvalid;
            if (s_axis_tvalid && s_axis_tready) begin
                t = table_update(s_axis_tuser, s_axis_tdata[ADDR_W-1:0]);
                tally_q.push_back(t);
                sent++;
                offer = 1'b0;
                // every third run of 64 transfers goes without gaps
                gap_left = ((sent / 64) % 3 == 1) ? 0 : idle_len();
            end
            if (!offer) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (pending.size() != 0 &&
                             !(pending[0].drain && tally_q.size() != 0)) begin
                    p = pending.pop_front();
                    s_axis_tdata <= IN_TDATA_W'(p.addr);
                    s_axis_tuser <= p.op;
                    offer = 1'b1;
                end
            end
            s_axis_tvalid <= offer;
        end
    end

    // monitor and receiver stalls
    always @(posedge i_clk) begin
        int     stall_left;
        bit     held_long;
        t_tally want;
        t_tally got;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            stall_left = 0;
            held_long = 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got.found   = m_axis_tdata[0];
                got.hits    = m_axis_tdata[1 +: HITS_W];
                got.entries = m_axis_tdata[1 + HITS_W +: ENTRIES_W];
                got.dropped = m_axis_tdata[1 + HITS_W + ENTRIES_W];
                if (tally_q.size() == 0) begin
                    $display("%0t ns: result with none expected, actual 0x%0h",
                             $time, m_axis_tdata);
                    errors++;
                end else begin
                    want = tally_q.pop_front();
                    check_field("found",   32'(want.found),   32'(got.found));
                    check_field("hits",    want.hits,         got.hits);
                    check_field("entries", 32'(want.entries), 32'(got.entries));
                    check_field("dropped", 32'(want.dropped), 32'(got.dropped));
                    n_found   += want.found;
                    n_dropped += want.dropped;
                    if (want.entries > peak_entries) peak_entries = want.entries;
                end
                results++;
                // one long hold-off while the sender keeps offering
                if (results == 200 && !held_long) begin
                    held_long = 1'b1;
                    stall_left = 500;
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end else begin
                if ((results / 50) % 3 != 2 && $urandom_range(0, 3) == 0)
                    stall_left = idle_len();
                m_axis_tready <= (stall_left == 0);
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results outstanding", cycles, tally_q.size());
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        int          i;
        int          r;
        int          k;
        logic [31:0] a;

        // directed: empty table, extremes, inserts that shift, repeats, lookups
        add_probe(OP_LOOKUP, 32'h0000_0000, 1'b0);
        add_probe(OP_COUNT,  32'hFFFF_FFFF, 1'b0);
        add_probe(OP_COUNT,  32'h0000_0000, 1'b0);
        add_probe(OP_COUNT,  32'h8000_0000, 1'b0);
        add_probe(OP_COUNT,  32'h7FFF_FFFF, 1'b0);
        add_probe(OP_COUNT,  32'h0000_0000, 1'b0);
        add_probe(OP_COUNT,  32'hFFFF_FFFF, 1'b0);
        add_probe(OP_COUNT,  32'hFFFF_FFFF, 1'b0);
        add_probe(OP_LOOKUP, 32'hFFFF_FFFF, 1'b0);
        add_probe(OP_LOOKUP, 32'h8000_0001, 1'b0);
        add_probe(OP_LOOKUP, 32'h0000_0000, 1'b0);
        add_probe(OP_COUNT,  32'h0000_0001, 1'b0);
        add_probe(OP_COUNT,  32'hAAAA_AAAA, 1'b0);
        add_probe(OP_COUNT,  32'h5555_5555, 1'b0);
        add_probe(OP_LOOKUP, 32'h5555_5555, 1'b0);
        add_probe(OP_LOOKUP, 32'h7FFF_FFFE, 1'b1);
        add_probe(OP_COUNT,  32'h7FFF_FFFF, 1'b0);
        add_probe(OP_LOOKUP, 32'hFFFF_FFFE, 1'b0);

        // random: repeats, fresh inserts, lookups, near misses around stored keys
        for (i = 0; i < 550; i++) begin
            r = $urandom_range(0, 99);
            if (r < 35) begin
                add_probe(OP_COUNT, pick_known(), 1'b0);
            end else if (r < 60) begin
                add_probe(OP_COUNT, $urandom(), 1'b0);
            end else if (r < 75) begin
                add_probe(OP_LOOKUP, pick_known(), 1'b0);
            end else if (r < 85) begin
                add_probe(OP_LOOKUP, $urandom(), 1'b0);
            end else begin
                a = pick_known() + ($urandom_range(0, 1) ? 32'd1 : 32'hFFFF_FFFF);
                add_probe($urandom_range(0, 1) ? OP_COUNT : OP_LOOKUP, a, 1'b0);
            end
            if ($urandom_range(0, 99) == 0) pending[$].drain = 1'b1;
        end

        // fill to capacity near the top so each insert moves only a few entries
        k = 0;
        while (issued.size() < CAPACITY) begin
            a = 32'hFFFF_0000 + k;
            if (!issued.exists(a)) add_probe(OP_COUNT, a, 1'b0);
            k++;
        end
        pending[$].drain = 1'b1;

        // full table: drops, counts and lookups on stored keys, lookups on absent keys
        for (i = 0; i < 80; i++) begin
            r = $urandom_range(0, 99);
            if (r < 30) begin
                a = pick_absent();
                add_probe(OP_COUNT, a, 1'b0);
                issued.delete(a);
                void'(known.pop_back());
            end else if (r < 60) begin
                add_probe(OP_COUNT, pick_known(), 1'b0);
            end else if (r < 80) begin
                add_probe(OP_LOOKUP, pick_known(), 1'b0);
            end else begin
                add_probe(OP_LOOKUP, pick_absent(), 1'b0);
            end
        end

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        do @(posedge i_clk);
        while (pending.size() != 0 || s_axis_tvalid || tally_q.size() != 0);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        if (tally_q.size() != 0) begin
            $display("%0d expected results never arrived", tally_q.size());
            errors++;
        end
        $display("Sent %0d transfers, got %0d results: %0d found, %0d dropped, peak %0d entries",
                 sent, results, n_found, n_dropped, peak_entries);
        $display("Mismatches: %0d, cycles: %0d", errors, cycles);
        if (errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
